/* rtl/fmmr_pkg.sv */
package fmmr_pkg;

   localparam int CompWidth  = 32;
   localparam int MassWidth  = CompWidth - 1;
   localparam int TolWidth   = 16;
   localparam int SqWidth    = 2 * CompWidth;
   localparam int RootSteps  = CompWidth;
   localparam int DivSteps   = CompWidth;

   localparam logic [TolWidth-1:0] TolReset = 16'd7;

   localparam int StgSquare   = 1;
   localparam int StgMsq      = 2;
   localparam int StgRoot1Lo  = 3;
   localparam int StgRoot1Hi  = StgRoot1Lo + RootSteps - 1;
   localparam int StgMass     = StgRoot1Hi + 1;
   localparam int StgNumer    = StgMass + 1;
   localparam int StgDivLo    = StgNumer + 1;
   localparam int StgDivHi    = StgDivLo + DivSteps - 1;
   localparam int StgClip     = StgDivHi + 1;
   localparam int StgSquare2  = StgClip + 1;
   localparam int StgSum      = StgSquare2 + 1;
   localparam int StgRoot2Lo  = StgSum + 1;
   localparam int StgRoot2Hi  = StgRoot2Lo + RootSteps - 1;
   localparam int StgLast     = StgRoot2Hi + 1;

   typedef struct packed {
      logic [3:0]                          neg;
      logic [3:0][CompWidth-1:0]           raw;
      logic [3:0][CompWidth-1:0]           mag;
      logic [MassWidth-1:0]                target;
      logic                                cons;
      logic [SqWidth-1:0]                  rad;
      logic [CompWidth+1:0]                rem;
      logic [CompWidth-1:0]                root;
      logic [CompWidth-1:0]                mass;
      logic                                resc;
      logic                                zm;
      logic                                sat;
      logic [2:0]                          dsat;
      logic [2:0][CompWidth-1:0]           dq;
      logic [2:0][CompWidth-1:0]           drem;
      logic [2:0][CompWidth-1:0]           dlo;
      logic [3:0][SqWidth-1:0]             sq;
   } pipe_type;

endpackage

/* rtl/four_momentum_mass_rescale_top.sv */
// Channel   Direction  Transfer when          Payload
// req       in         req_valid & req_ready  energy, mom_x/y/z, target_mass
// rsp       out        rsp_valid & rsp_ready  rest_mass, flags, out_energy, out_x/y/z
// csr       in         csr_wr_en              mass_tolerance
//
// One item per cycle moves from req to rsp while no rsp item is held.
// The two square roots and the three divisions resolve one bit per stage.
// Reset clears all valid bits and loads mass_tolerance with 7.
// A held rsp item freezes every stage; req_ready drops only then.
module four_momentum_mass_rescale_top
   import fmmr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_energy,
   input  logic [31:0]          req_mom_x,
   input  logic [31:0]          req_mom_y,
   input  logic [31:0]          req_mom_z,
   input  logic [30:0]          req_target_mass,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [30:0]          rsp_rest_mass,
   output logic                 rsp_consistent,
   output logic                 rsp_rescaled,
   output logic                 rsp_zero_mass,
   output logic                 rsp_saturated,
   output logic [31:0]          rsp_out_energy,
   output logic [31:0]          rsp_out_x,
   output logic [31:0]          rsp_out_y,
   output logic [31:0]          rsp_out_z,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data
);

   pipe_type                pipe_ff [0:StgLast];
   pipe_type                pipe_in [0:StgLast];
   logic [StgLast:0]        valid_ff;
   logic [TolWidth-1:0]     tol_ff;
   logic                    adv;

   function automatic pipe_type root_step(input pipe_type p);
      pipe_type             r;
      logic [CompWidth+3:0] t;
      logic [CompWidth+3:0] trial;
      r     = p;
      t     = {p.rem, p.rad[SqWidth-1 -: 2]};
      trial = {2'b00, p.root, 2'b01};
      if (t >= trial) begin
         r.rem  = (CompWidth+2)'(t - trial);
         r.root = {p.root[CompWidth-2:0], 1'b1};
      end else begin
         r.rem  = (CompWidth+2)'(t);
         r.root = {p.root[CompWidth-2:0], 1'b0};
      end
      r.rad = {p.rad[SqWidth-3:0], 2'b00};
      return r;
   endfunction

   function automatic pipe_type div_step(input pipe_type p);
      pipe_type           r;
      logic [CompWidth:0] t;
      r = p;
      for (int i = 0; i < 3; i++) begin
         t = {p.drem[i], p.dlo[i][CompWidth-1]};
         if (t >= {1'b0, p.mass}) begin
            r.drem[i] = CompWidth'(t - {1'b0, p.mass});
            r.dq[i]   = {p.dq[i][CompWidth-2:0], 1'b1};
         end else begin
            r.drem[i] = CompWidth'(t);
            r.dq[i]   = {p.dq[i][CompWidth-2:0], 1'b0};
         end
         r.dlo[i] = {p.dlo[i][CompWidth-2:0], 1'b0};
      end
      return r;
   endfunction

   assign adv       = !valid_ff[StgLast] || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      logic [3:0][CompWidth-1:0] v;
      pipe_type                  p;
      v        = {req_mom_z, req_mom_y, req_mom_x, req_energy};
      p        = pipe_ff[0];
      p.raw    = v;
      p.target = req_target_mass;
      for (int i = 0; i < 4; i++) begin
         p.neg[i] = v[i][CompWidth-1];
         p.mag[i] = v[i][CompWidth-1] ? CompWidth'(~v[i] + 1'b1) : v[i];
      end
      pipe_in[0] = p;
   end

   always_comb begin
      for (int k = 1; k <= StgLast; k++) begin
         pipe_type                 p;
         logic [SqWidth-1:0]       esq;
         logic [SqWidth-1:0]       psq;
         logic [CompWidth-1:0]     diff;
         logic                     need;
         logic [SqWidth-1:0]       n;
         logic                     over;
         logic [CompWidth-1:0]     lim;
         p    = pipe_ff[k-1];
         esq  = '0;
         psq  = '0;
         diff = '0;
         need = 1'b0;
         n    = '0;
         over = 1'b0;
         lim  = '0;
         if (k == StgSquare) begin
            for (int i = 0; i < 4; i++) begin
               p.sq[i] = SqWidth'(p.mag[i]) * SqWidth'(p.mag[i]);
            end
         end else if (k == StgMsq) begin
            esq    = p.sq[0];
            psq    = p.sq[1] + p.sq[2] + p.sq[3];
            p.cons = !p.neg[0] && (psq <= esq);
            p.rad  = (esq > psq) ? esq - psq : '0;
            p.rem  = '0;
            p.root = '0;
         end else if ((k >= StgRoot1Lo && k <= StgRoot1Hi) ||
                      (k >= StgRoot2Lo && k <= StgRoot2Hi)) begin
            p = root_step(p);
         end else if (k == StgMass) begin
            p.mass  = p.root;
            diff    = (p.mass > {1'b0, p.target}) ? p.mass - {1'b0, p.target}
                                                  : {1'b0, p.target} - p.mass;
            need    = diff > CompWidth'(tol_ff);
            p.zm    = need && (p.mass == '0);
            p.resc  = need && (p.mass != '0);
            p.sat   = 1'b0;
            p.sq[0] = SqWidth'(p.target) * SqWidth'(p.target);
            for (int i = 1; i < 4; i++) begin
               p.sq[i] = SqWidth'(p.mag[i]) * SqWidth'(p.target);
            end
         end else if (k == StgNumer) begin
            for (int i = 0; i < 3; i++) begin
               n         = p.sq[i+1] + SqWidth'(p.mass[CompWidth-1:1]);
               p.dsat[i] = n[SqWidth-1:CompWidth] >= p.mass;
               p.drem[i] = n[SqWidth-1:CompWidth];
               p.dlo[i]  = n[CompWidth-1:0];
               p.dq[i]   = '0;
            end
         end else if (k >= StgDivLo && k <= StgDivHi) begin
            p = div_step(p);
         end else if (k == StgClip) begin
            for (int i = 0; i < 3; i++) begin
               lim  = p.neg[i+1] ? {1'b1, {(CompWidth-1){1'b0}}}
                                 : {1'b0, {(CompWidth-1){1'b1}}};
               over = p.dsat[i] || (p.dq[i] > lim);
               if (over) begin
                  p.dq[i] = lim;
               end
               p.sat = p.sat || (over && p.resc);
            end
         end else if (k == StgSquare2) begin
            for (int i = 1; i < 4; i++) begin
               p.sq[i] = SqWidth'(p.dq[i-1]) * SqWidth'(p.dq[i-1]);
            end
         end else if (k == StgSum) begin
            p.rad  = p.sq[0] + p.sq[1] + p.sq[2] + p.sq[3];
            p.rem  = '0;
            p.root = '0;
         end else if (k == StgLast) begin
            if (p.resc) begin
               if (p.root[CompWidth-1]) begin
                  p.raw[0] = {1'b0, {(CompWidth-1){1'b1}}};
                  p.sat    = 1'b1;
               end else begin
                  p.raw[0] = p.root;
               end
               for (int i = 1; i < 4; i++) begin
                  p.raw[i] = p.neg[i] ? CompWidth'(~p.dq[i-1] + 1'b1) : p.dq[i-1];
               end
            end
         end
         pipe_in[k] = p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[StgLast-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= StgLast; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TolReset;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   assign rsp_valid      = valid_ff[StgLast];
   assign rsp_rest_mass  = pipe_ff[StgLast].mass[CompWidth-1] ? {MassWidth{1'b1}}
                                                              : pipe_ff[StgLast].mass[MassWidth-1:0];
   assign rsp_consistent = pipe_ff[StgLast].cons;
   assign rsp_rescaled   = pipe_ff[StgLast].resc;
   assign rsp_zero_mass  = pipe_ff[StgLast].zm;
   assign rsp_saturated  = pipe_ff[StgLast].sat;
   assign rsp_out_energy = pipe_ff[StgLast].raw[0];
   assign rsp_out_x      = pipe_ff[StgLast].raw[1];
   assign rsp_out_y      = pipe_ff[StgLast].raw[2];
   assign rsp_out_z      = pipe_ff[StgLast].raw[3];

endmodule

/* rtl/fmmr_checker.sv */
module fmmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_rescaled,
   input logic        rsp_zero_mass,
   input logic        rsp_saturated,
   input logic [31:0] rsp_out_energy,
   input logic [31:0] rsp_out_x
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("rsp item dropped or changed while stalled");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_rescaled && rsp_zero_mass))
      else $error("rescaled and zero_mass both set");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rescaled |-> !rsp_saturated)
      else $error("saturated without rescale");

   a_energy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rescaled |-> !rsp_out_energy[31])
      else $error("rescaled energy negative");

endmodule

bind four_momentum_mass_rescale_top fmmr_checker u_fmmr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_rescaled   (rsp_rescaled),
   .rsp_zero_mass  (rsp_zero_mass),
   .rsp_saturated  (rsp_saturated),
   .rsp_out_energy (rsp_out_energy),
   .rsp_out_x      (rsp_out_x)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
   import fmmr_pkg::*;

   typedef struct packed {
      logic [31:0] energy;
      logic [31:0] mom_x;
      logic [31:0] mom_y;
      logic [31:0] mom_z;
      logic [30:0] target;
   } four_vec_type;

   typedef struct packed {
      logic [30:0] rest_mass;
      logic        consistent;
      logic        rescaled;
      logic        zero_mass;
      logic        saturated;
      logic [31:0] energy;
      logic [31:0] mom_x;
      logic [31:0] mom_y;
      logic [31:0] mom_z;
   } mass_result_type;

   localparam logic [127:0] HalfRange = 128'h8000_0000;
   localparam int IdleLimit = 5000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   four_vec_type req_vec;
   logic rsp_valid;
   logic rsp_ready;
   mass_result_type rsp;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;

   logic [15:0] tolerance;
   mass_result_type expected_results[$];
   int error_count;
   int burst_left;
   int hold_off;
   int idle_cycles;

   four_momentum_mass_rescale_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_energy(req_vec.energy),
      .req_mom_x(req_vec.mom_x),
      .req_mom_y(req_vec.mom_y),
      .req_mom_z(req_vec.mom_z),
      .req_target_mass(req_vec.target),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_rest_mass(rsp.rest_mass),
      .rsp_consistent(rsp.consistent),
      .rsp_rescaled(rsp.rescaled),
      .rsp_zero_mass(rsp.zero_mass),
      .rsp_saturated(rsp.saturated),
      .rsp_out_energy(rsp.energy),
      .rsp_out_x(rsp.mom_x),
      .rsp_out_y(rsp.mom_y),
      .rsp_out_z(rsp.mom_z),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] floor_sqrt(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if ({64'd0, t} * {64'd0, t} <= n) begin
            r = t;
         end
      end
      return r;
   endfunction

   function automatic mass_result_type predict_invariant_mass(four_vec_type v, logic [15:0] tol);
      mass_result_type r;
      logic [31:0] comp[4];
      logic neg[4];
      logic [127:0] mag[4];
      logic [127:0] esq;
      logic [127:0] psq;
      logic [127:0] sum;
      logic [127:0] q;
      logic [127:0] lim;
      logic [63:0] mass;
      logic [63:0] diff;
      logic [63:0] e;
      logic [31:0] res[4];
      comp[0] = v.energy;
      comp[1] = v.mom_x;
      comp[2] = v.mom_y;
      comp[3] = v.mom_z;
      for (int i = 0; i < 4; i++) begin
         neg[i] = comp[i][31];
         mag[i] = neg[i] ? (128'h1_0000_0000 - comp[i]) : {96'd0, comp[i]};
         res[i] = comp[i];
      end
      esq = mag[0] * mag[0];
      psq = mag[1] * mag[1] + mag[2] * mag[2] + mag[3] * mag[3];
      r = '0;
      r.consistent = !neg[0] && (psq <= esq);
      mass = floor_sqrt(esq > psq ? esq - psq : 128'd0);
      diff = (mass > v.target) ? mass - v.target : v.target - mass;
      if (diff > tol) begin
         if (mass == 0) begin
            r.zero_mass = 1'b1;
         end else begin
            sum = v.target * v.target;
            for (int i = 1; i < 4; i++) begin
               q = (mag[i] * v.target + (mass >> 1)) / mass;
               lim = neg[i] ? HalfRange : HalfRange - 1;
               if (q > lim) begin
                  q = lim;
                  r.saturated = 1'b1;
               end
               res[i] = neg[i] ? 32'(0 - q[31:0]) : q[31:0];
               sum = sum + q * q;
            end
            e = floor_sqrt(sum);
            if (e > 64'h7FFF_FFFF) begin
               e = 64'h7FFF_FFFF;
               r.saturated = 1'b1;
            end
            res[0] = e[31:0];
            r.rescaled = 1'b1;
         end
      end
      r.rest_mass = (mass > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : mass[30:0];
      r.energy = res[0];
      r.mom_x = res[1];
      r.mom_y = res[2];
      r.mom_z = res[3];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch: got %h expected %h", $time, field, got, want);
      error_count++;
   endtask

   // checker
   always @(posedge clock) begin
      mass_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result transfer", $time);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp.rest_mass !== want.rest_mass)
               report_mismatch("rest_mass", 32'(rsp.rest_mass), 32'(want.rest_mass));
            if (rsp.consistent !== want.consistent)
               report_mismatch("consistent", 32'(rsp.consistent), 32'(want.consistent));
            if (rsp.rescaled !== want.rescaled)
               report_mismatch("rescaled", 32'(rsp.rescaled), 32'(want.rescaled));
            if (rsp.zero_mass !== want.zero_mass)
               report_mismatch("zero_mass", 32'(rsp.zero_mass), 32'(want.zero_mass));
            if (rsp.saturated !== want.saturated)
               report_mismatch("saturated", 32'(rsp.saturated), 32'(want.saturated));
            if (rsp.energy !== want.energy)
               report_mismatch("out_energy", rsp.energy, want.energy);
            if (rsp.mom_x !== want.mom_x)
               report_mismatch("out_x", rsp.mom_x, want.mom_x);
            if (rsp.mom_y !== want.mom_y)
               report_mismatch("out_y", rsp.mom_y, want.mom_y);
            if (rsp.mom_z !== want.mom_z)
               report_mismatch("out_z", rsp.mom_z, want.mom_z);
         end
      end
   end

   // receiver stall pattern
   initial begin
      int mode;
      int span;
      rsp_ready = 1'b0;
      mode = 0;
      span = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 80);
         end
         span--;
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if (mode == 0) begin
            rsp_ready <= 1'b1;
         end else if (mode == 1) begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end else begin
            rsp_ready <= ($urandom_range(0, 7) != 0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (!req_valid && expected_results.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_vector(four_vec_type v);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_vec <= v;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_invariant_mass(v, tolerance));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [15:0] value);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tolerance = value;
   endtask

   function automatic logic [31:0] random_component();
      logic [31:0] m;
      m = $urandom >> $urandom_range(0, 31);
      return ($urandom_range(0, 1) == 1) ? 32'(0 - m) : m;
   endfunction

   // mostly physical vectors: energy built from momentum and a chosen mass
   function automatic four_vec_type random_vector();
      four_vec_type v;
      logic [127:0] px;
      logic [127:0] py;
      logic [127:0] pz;
      logic [63:0] m;
      logic [63:0] e;
      int kind;
      kind = $urandom_range(0, 9);
      v.mom_x = random_component() >>> $urandom_range(0, 2);
      v.mom_y = random_component() >>> $urandom_range(0, 2);
      v.mom_z = random_component() >>> $urandom_range(0, 2);
      v.target = 31'($urandom >> $urandom_range(1, 31));
      if (kind < 7) begin
         px = v.mom_x[31] ? 128'h1_0000_0000 - v.mom_x : {96'd0, v.mom_x};
         py = v.mom_y[31] ? 128'h1_0000_0000 - v.mom_y : {96'd0, v.mom_y};
         pz = v.mom_z[31] ? 128'h1_0000_0000 - v.mom_z : {96'd0, v.mom_z};
         m = 64'($urandom >> $urandom_range(1, 31));
         e = floor_sqrt(px * px + py * py + pz * pz + m * m);
         v.energy = (e > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : e[31:0];
         if (kind < 3)
            v.target = 31'(m + $urandom_range(0, 20) - 10);
      end else begin
         v.energy = random_component();
      end
      return v;
   endfunction

   task automatic test_directed();
      send_vector('{32'd0, 32'd0, 32'd0, 32'd0, 31'd0});
      send_vector('{32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 31'h0004_0000});
      send_vector('{32'h8000_0000, 32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF});
      send_vector('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd5});
      send_vector('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF});
      send_vector('{32'hFFFE_0000, 32'h0000_8000, 32'd0, 32'd0, 31'h0001_0000});
      send_vector('{32'h0005_0000, 32'h0003_0000, 32'h0004_0000, 32'd0, 31'd0});
      send_vector('{32'h0005_0000, 32'h0003_0000, 32'hFFFC_0000, 32'd0, 31'd7});
      send_vector('{32'h0005_0000, 32'h0003_0000, 32'hFFFC_0000, 32'd0, 31'd8});
      send_vector('{32'h0005_0000, 32'hFFFD_0000, 32'h0004_0000, 32'd0, 31'h0006_0000});
      send_vector('{32'h0000_0002, 32'h7FFF_FFFF, 32'h8000_0001, 32'd1, 31'h7FFF_FFFF});
      send_vector('{32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 31'd0});
      send_vector('{32'h0002_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 31'd1});
      send_vector('{32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0, 31'h0001_0000});
      send_vector('{32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h0, 32'h0, 31'h7FFF_FFFF});
      send_vector('{32'h0100_0000, 32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0005, 31'h0000_0002});
      send_vector('{32'h8000_0000, 32'd0, 32'd0, 32'd0, 31'h0001_0000});
   endtask

   task automatic test_random_stream(int count);
      for (int n = 0; n < count; n++)
         send_vector(random_vector());
   endtask

   task automatic test_tolerance_settings();
      write_tolerance(16'd0);
      test_directed();
      test_random_stream(60);
      write_tolerance(16'hFFFF);
      test_directed();
      test_random_stream(60);
      write_tolerance(16'($urandom_range(1, 65534)));
      test_random_stream(60);
      write_tolerance(TolReset);
   endtask

   task automatic test_backpressure();
      drain();
      hold_off = 400;
      test_random_stream(150);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_vec = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_off = 0;
      burst_left = 0;
      error_count = 0;
      idle_cycles = 0;
      tolerance = TolReset;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_stream(200);
      test_tolerance_settings();
      test_backpressure();
      test_random_stream(40);
      drain();
      repeat (120) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/fmmr_pkg.sv
rtl/four_momentum_mass_rescale_top.sv
rtl/fmmr_checker.sv
tb/tb.sv
